// File: sv/complex_alu_with_peak_tracker_top_defines.svh
// Assertion macros used by the top-level RTL
`ifndef COMPLEX_ALU_WITH_PEAK_TRACKER_TOP_DEFINES_SVH
`define COMPLEX_ALU_WITH_PEAK_TRACKER_TOP_DEFINES_SVH

// checked outside reset
`define CAPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define CAPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/capt_pkg.sv
package capt_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned QDepth   = 2;

  typedef logic [3:0] opcode_t;
  localparam opcode_t OpLoad = 4'd0;
  localparam opcode_t OpNeg  = 4'd1;
  localparam opcode_t OpAdd  = 4'd2;
  localparam opcode_t OpSub  = 4'd3;
  localparam opcode_t OpMul  = 4'd4;
  localparam opcode_t OpEq   = 4'd5;
  localparam opcode_t OpNe   = 4'd6;
  localparam opcode_t OpMag  = 4'd7;
  localparam opcode_t OpNorm = 4'd8;
  localparam opcode_t OpPeak = 4'd9;

  typedef enum logic [3:0] {
    K_LOAD, K_NEG, K_ADD, K_SUB, K_MUL, K_EQ, K_NE, K_MAG, K_NORM, K_PEAK, K_NONE
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } item_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [31:0]        mag;
    logic               cmp;
    logic               sat;
  } result_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] cnt;
  } qstat_t;

  // {clip, value}: clamp a wide signed value to the 32-bit range
  function automatic logic [32:0] sat66(input logic signed [65:0] v);
    logic [32:0] r;
    if ((&v[65:31]) || !(|v[65:31])) begin
      r = {1'b0, v[31:0]};
    end else if (v[65]) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b1, 32'h7fff_ffff};
    end
    return r;
  endfunction

endpackage

// File: sv/complex_alu_with_peak_tracker_top.sv
// Channel  | Dir | Beat contents
// s_axis   | in  | tuser: opcode[3:0]; tdata: a_re, a_im, b_re, b_im (32b each, low first)
// m_axis   | out | tdata: res_re, res_im, res_mag, compare_true, saturated, zero pad
//
// One item at a time from queue pop to result. Eq, ne, read peak and unused codes end
// after execute; load, negate, add, sub, magnitude and mul run the 32-step square root;
// normalize, on a nonzero root, then runs the 17-step divider and the root again.
// A 2-entry queue takes beats while the back end works or the output stalls.
// Reset (rst_ni low, async) clears the queue, the output and the peak.
`include "complex_alu_with_peak_tracker_top_defines.svh"

module complex_alu_with_peak_tracker_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [127:0]  s_axis_tdata_i,   // a_re, a_im, b_re, b_im
  input  logic [3:0]    s_axis_tuser_i,   // opcode
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [103:0]  m_axis_tdata_o    // res_re, res_im, res_mag, compare_true, saturated
);

  capt_pkg::item_t   item;
  capt_pkg::qstat_t  q_stat;
  capt_pkg::result_t res;
  logic              pop;

  capt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .opcode_i   (s_axis_tuser_i),
    .a_re_i     (s_axis_tdata_i[31:0]),
    .a_im_i     (s_axis_tdata_i[63:32]),
    .b_re_i     (s_axis_tdata_i[95:64]),
    .b_im_i     (s_axis_tdata_i[127:96]),
    .pop_i      (pop),
    .item_o     (item),
    .stat_o     (q_stat)
  );

  capt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .stat_i      (q_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  assign m_axis_tdata_o = {6'd0, res.sat, res.cmp, res.mag, res.im, res.re};

  `CAPT_ASSERT(a_flags_excl, m_axis_tvalid_o |-> !(m_axis_tdata_o[96] && m_axis_tdata_o[97]), "cmp and sat both set")
  `CAPT_ASSERT(a_cmp_zero, (m_axis_tvalid_o && m_axis_tdata_o[96]) |-> (m_axis_tdata_o[95:0] == '0), "compare beat carries data")
  `CAPT_ASSERT_ALWAYS(a_full_stall, (q_stat.cnt == 2'(capt_pkg::QDepth)) |-> !s_axis_tready_o, "ready while queue full")

endmodule

// File: sv/capt_front.sv
module capt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  capt_pkg::opcode_t   opcode_i,
  input  logic signed [31:0]  a_re_i,
  input  logic signed [31:0]  a_im_i,
  input  logic signed [31:0]  b_re_i,
  input  logic signed [31:0]  b_im_i,
  input  logic                pop_i,
  output capt_pkg::item_t     item_o,
  output capt_pkg::qstat_t    stat_o
);

  capt_pkg::kind_e kind;
  capt_pkg::item_t mem_q [capt_pkg::QDepth];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;
  logic            push, pop;

  always_comb begin
    case (opcode_i)
      capt_pkg::OpLoad: kind = capt_pkg::K_LOAD;
      capt_pkg::OpNeg:  kind = capt_pkg::K_NEG;
      capt_pkg::OpAdd:  kind = capt_pkg::K_ADD;
      capt_pkg::OpSub:  kind = capt_pkg::K_SUB;
      capt_pkg::OpMul:  kind = capt_pkg::K_MUL;
      capt_pkg::OpEq:   kind = capt_pkg::K_EQ;
      capt_pkg::OpNe:   kind = capt_pkg::K_NE;
      capt_pkg::OpMag:  kind = capt_pkg::K_MAG;
      capt_pkg::OpNorm: kind = capt_pkg::K_NORM;
      capt_pkg::OpPeak: kind = capt_pkg::K_PEAK;
      default:          kind = capt_pkg::K_NONE;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'(capt_pkg::QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != 2'd0);
  assign item_o     = mem_q[rd_q];
  assign stat_o     = '{vld: (cnt_q != 2'd0), cnt: cnt_q};

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{kind: kind, a_re: a_re_i, a_im: a_im_i, b_re: b_re_i, b_im: b_im_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// File: sv/capt_back.sv
module capt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  capt_pkg::item_t    item_i,
  input  capt_pkg::qstat_t   stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output capt_pkg::result_t  out_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_EXEC = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_SQ   = 7'b0001000,
    ST_SQRT = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  state_e             state_q;
  capt_pkg::kind_e    kind_q;
  logic signed [31:0] ar_q, ai_q, br_q, bi_q;
  logic signed [31:0] re_q, im_q;
  logic [31:0]        mag_q;
  logic               cmp_q, sat_q, made_q, norm_q;
  logic [4:0]         cnt_q;
  logic signed [31:0] mx, my;
  logic signed [63:0] prod_q;
  logic signed [65:0] acc_re_q, acc_im_q;
  logic [63:0]        sum_q, rad_q;
  logic [33:0]        rem_q;
  logic [31:0]        root_q;
  logic [35:0]        r2, trial;
  logic [33:0]        rem_d;
  logic [31:0]        root_d;
  logic [32:0]        dre_q, dim_q;
  logic [16:0]        nre_q, nim_q, qre_q, qim_q;
  logic [32:0]        tre, tim;
  logic [32:0]        dre_d, dim_d;
  logic [16:0]        qre_d, qim_d;
  logic [31:0]        abs_re, abs_im;
  logic signed [32:0] add_re, add_im, sub_re, sub_im;
  logic [32:0]        s_re, s_im;
  logic [31:0]        peak_re_q, peak_im_q, peak_mag_q;
  logic               out_vld_q;
  capt_pkg::result_t  out_q;
  logic               out_free;
  logic               emit;

  assign pop_o       = (state_q == ST_IDLE) && stat_i.vld;
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;
  assign out_free    = !out_vld_q || out_ready_i;
  assign emit        = (state_q == ST_DONE) && out_free;

  always_comb begin
    mx = ar_q;
    my = br_q;
    if (state_q == ST_MUL) begin
      case (cnt_q)
        5'd1:    begin mx = ai_q; my = bi_q; end
        5'd2:    begin mx = ar_q; my = bi_q; end
        5'd3:    begin mx = ai_q; my = br_q; end
        default: begin mx = ar_q; my = br_q; end
      endcase
    end else if (cnt_q == 5'd0) begin
      mx = re_q;
      my = re_q;
    end else begin
      mx = im_q;
      my = im_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mx * my;
  end

  // one root bit per cycle
  always_comb begin
    r2    = {rem_q, rad_q[63:62]};
    trial = {2'b00, root_q, 2'b01};
    if (r2 >= trial) begin
      rem_d  = 34'(r2 - trial);
      root_d = {root_q[30:0], 1'b1};
    end else begin
      rem_d  = r2[33:0];
      root_d = {root_q[30:0], 1'b0};
    end
  end

  // one quotient bit per cycle for each part
  always_comb begin
    tre = {dre_q[31:0], nre_q[16]};
    tim = {dim_q[31:0], nim_q[16]};
    if (tre >= {1'b0, mag_q}) begin
      dre_d = tre - {1'b0, mag_q};
      qre_d = {qre_q[15:0], 1'b1};
    end else begin
      dre_d = tre;
      qre_d = {qre_q[15:0], 1'b0};
    end
    if (tim >= {1'b0, mag_q}) begin
      dim_d = tim - {1'b0, mag_q};
      qim_d = {qim_q[15:0], 1'b1};
    end else begin
      dim_d = tim;
      qim_d = {qim_q[15:0], 1'b0};
    end
  end

  assign abs_re = ar_q[31] ? 32'(-ar_q) : ar_q;
  assign abs_im = ai_q[31] ? 32'(-ai_q) : ai_q;
  assign add_re = 33'(ar_q) + 33'(br_q);
  assign add_im = 33'(ai_q) + 33'(bi_q);
  assign sub_re = 33'(ar_q) - 33'(br_q);
  assign sub_im = 33'(ai_q) - 33'(bi_q);

  always_comb begin
    if (kind_q == capt_pkg::K_ADD) begin
      s_re = capt_pkg::sat66(66'(add_re));
      s_im = capt_pkg::sat66(66'(add_im));
    end else if (kind_q == capt_pkg::K_SUB) begin
      s_re = capt_pkg::sat66(66'(sub_re));
      s_im = capt_pkg::sat66(66'(sub_im));
    end else begin
      s_re = capt_pkg::sat66(acc_re_q >>> capt_pkg::FracBits);
      s_im = capt_pkg::sat66(acc_im_q >>> capt_pkg::FracBits);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        kind_q <= item_i.kind;
        ar_q   <= item_i.a_re;
        ai_q   <= item_i.a_im;
        br_q   <= item_i.b_re;
        bi_q   <= item_i.b_im;
        cmp_q  <= 1'b0;
        sat_q  <= 1'b0;
        made_q <= 1'b0;
        norm_q <= 1'b0;
        mag_q  <= '0;
        cnt_q  <= '0;
      end
      ST_EXEC: begin
        cnt_q <= '0;
        re_q  <= ar_q;
        im_q  <= ai_q;
        case (kind_q)
          capt_pkg::K_LOAD: made_q <= 1'b1;
          capt_pkg::K_NEG: begin
            re_q   <= (ar_q == 32'sh8000_0000) ? 32'sh7fff_ffff : 32'(-ar_q);
            im_q   <= (ai_q == 32'sh8000_0000) ? 32'sh7fff_ffff : 32'(-ai_q);
            made_q <= 1'b1;
          end
          capt_pkg::K_ADD, capt_pkg::K_SUB: begin
            re_q   <= s_re[31:0];
            im_q   <= s_im[31:0];
            sat_q  <= s_re[32] | s_im[32];
            made_q <= 1'b1;
          end
          capt_pkg::K_MUL: made_q <= 1'b1;
          capt_pkg::K_EQ: begin
            re_q  <= '0;
            im_q  <= '0;
            cmp_q <= (ar_q == br_q) && (ai_q == bi_q);
          end
          capt_pkg::K_NE: begin
            re_q  <= '0;
            im_q  <= '0;
            cmp_q <= (ar_q != br_q) || (ai_q != bi_q);
          end
          capt_pkg::K_MAG: ;
          capt_pkg::K_NORM: norm_q <= 1'b1;
          capt_pkg::K_PEAK: begin
            re_q  <= peak_re_q;
            im_q  <= peak_im_q;
            mag_q <= peak_mag_q;
          end
          default: begin
            re_q <= '0;
            im_q <= '0;
          end
        endcase
      end
      ST_MUL: begin
        cnt_q <= cnt_q + 5'd1;
        case (cnt_q)
          5'd1: acc_re_q <= 66'(prod_q);
          5'd2: acc_re_q <= acc_re_q - 66'(prod_q);
          5'd3: acc_im_q <= 66'(prod_q);
          5'd4: acc_im_q <= acc_im_q + 66'(prod_q);
          5'd5: begin
            re_q  <= s_re[31:0];
            im_q  <= s_im[31:0];
            sat_q <= s_re[32] | s_im[32];
            cnt_q <= '0;
          end
          default: ;
        endcase
      end
      ST_SQ: begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd1) sum_q <= prod_q;
        if (cnt_q == 5'd2) begin
          rad_q  <= sum_q + prod_q;
          rem_q  <= '0;
          root_q <= '0;
          cnt_q  <= '0;
        end
      end
      ST_SQRT: begin
        rem_q  <= rem_d;
        root_q <= root_d;
        rad_q  <= {rad_q[61:0], 2'b00};
        cnt_q  <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          mag_q <= root_d;
          cnt_q <= '0;
          if (norm_q) begin
            norm_q <= 1'b0;
            dre_q  <= {2'b00, abs_re[31:1]};
            dim_q  <= {2'b00, abs_im[31:1]};
            nre_q  <= {abs_re[0], 16'd0};
            nim_q  <= {abs_im[0], 16'd0};
            qre_q  <= '0;
            qim_q  <= '0;
          end
        end
      end
      ST_DIV: begin
        dre_q <= dre_d;
        dim_q <= dim_d;
        qre_q <= qre_d;
        qim_q <= qim_d;
        nre_q <= {nre_q[15:0], 1'b0};
        nim_q <= {nim_q[15:0], 1'b0};
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd16) begin
          re_q  <= ar_q[31] ? -$signed({15'd0, qre_d}) : $signed({15'd0, qre_d});
          im_q  <= ai_q[31] ? -$signed({15'd0, qim_d}) : $signed({15'd0, qim_d});
          cnt_q <= '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      out_vld_q  <= 1'b0;
      peak_re_q  <= '0;
      peak_im_q  <= '0;
      peak_mag_q <= '0;
    end else begin
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: if (stat_i.vld) state_q <= ST_EXEC;
        ST_EXEC: begin
          case (kind_q)
            capt_pkg::K_MUL: state_q <= ST_MUL;
            capt_pkg::K_LOAD, capt_pkg::K_NEG, capt_pkg::K_ADD, capt_pkg::K_SUB,
            capt_pkg::K_MAG, capt_pkg::K_NORM: state_q <= ST_SQ;
            default: state_q <= ST_DONE;
          endcase
        end
        ST_MUL:  if (cnt_q == 5'd5) state_q <= ST_SQ;
        ST_SQ:   if (cnt_q == 5'd2) state_q <= ST_SQRT;
        ST_SQRT: begin
          if (cnt_q == 5'd31) begin
            state_q <= (norm_q && (root_d != '0)) ? ST_DIV : ST_DONE;
          end
        end
        ST_DIV:  if (cnt_q == 5'd16) state_q <= ST_SQ;
        ST_DONE: begin
          if (out_free) begin
            out_q     <= '{re: re_q, im: im_q, mag: mag_q, cmp: cmp_q, sat: sat_q};
            state_q   <= ST_IDLE;
            if (made_q && (mag_q > peak_mag_q)) begin
              peak_re_q  <= re_q;
              peak_im_q  <= im_q;
              peak_mag_q <= mag_q;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: dv/testbench.sv
module testbench;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic [31:0] mag;
    logic        cmp;
    logic        sat;
  } res_s;

  typedef struct {
    capt_pkg::opcode_t op;
    logic [31:0]       ar, ai, br, bi;
    logic              known;
    res_s              want;
  } row_s;

  localparam logic [31:0] MaxPos = 32'h7fff_ffff;
  localparam logic [31:0] MinNeg = 32'h8000_0000;
  localparam int unsigned CycleLimit = 1500000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;
  logic [3:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [103:0] m_axis_tdata_o;

  always #6 clk_i = ~clk_i;

  complex_alu_with_peak_tracker_top dut (.*);

  logic signed [31:0] pk_re, pk_im;
  logic [31:0]        pk_mag;
  res_s               want_q[$];
  int                 errors = 0;
  int unsigned        cycles = 0;
  bit                 hold_long = 0;

  function automatic logic [31:0] isqrt(logic signed [31:0] re, logic signed [31:0] im);
    logic signed [65:0] wr, wi;
    logic [65:0] s;
    logic [32:0] r, t;
    wr = re;
    wi = im;
    s = 66'(wr * wr + wi * wi);
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      t = r | (33'd1 << b);
      if ({33'd0, t} * {33'd0, t} <= s) r = t;
    end
    return r[31:0];
  endfunction

  function automatic logic [31:0] clamp(logic signed [65:0] v, inout logic clip);
    if (v > 66'sd2147483647) begin
      clip = 1'b1;
      return MaxPos;
    end
    if (v < -66'sd2147483648) begin
      clip = 1'b1;
      return MinNeg;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] unit_part(logic signed [31:0] x, logic [31:0] m);
    logic [65:0] n, q;
    logic        d;
    n = (x < 0 ? 66'(-$signed({x[31], x})) : 66'(x)) << capt_pkg::FracBits;
    q = n / m;
    d = 1'b0;
    return clamp(x < 0 ? -$signed(q) : $signed(q), d);
  endfunction

  function automatic res_s predict(capt_pkg::opcode_t op, logic signed [31:0] ar, ai, br, bi);
    res_s r;
    logic made, d;
    r = '{default: '0};
    made = 1'b0;
    d = 1'b0;
    case (op)
      capt_pkg::OpLoad: begin
        r.re = ar; r.im = ai; made = 1;
      end
      capt_pkg::OpNeg: begin
        r.re = clamp(-66'(ar), d); r.im = clamp(-66'(ai), d); made = 1;
      end
      capt_pkg::OpAdd: begin
        r.re = clamp(66'(ar) + 66'(br), r.sat);
        r.im = clamp(66'(ai) + 66'(bi), r.sat); made = 1;
      end
      capt_pkg::OpSub: begin
        r.re = clamp(66'(ar) - 66'(br), r.sat);
        r.im = clamp(66'(ai) - 66'(bi), r.sat); made = 1;
      end
      capt_pkg::OpMul: begin
        r.re = clamp((66'(ar) * 66'(br) - 66'(ai) * 66'(bi)) >>> capt_pkg::FracBits, r.sat);
        r.im = clamp((66'(ar) * 66'(bi) + 66'(ai) * 66'(br)) >>> capt_pkg::FracBits, r.sat);
        made = 1;
      end
      capt_pkg::OpEq: r.cmp = (ar == br) && (ai == bi);
      capt_pkg::OpNe: r.cmp = (ar != br) || (ai != bi);
      capt_pkg::OpMag: begin
        r.re = ar; r.im = ai; r.mag = isqrt(ar, ai);
      end
      capt_pkg::OpNorm: begin
        r.mag = isqrt(ar, ai);
        if (r.mag == 0) begin
          r.re = ar; r.im = ai;
        end else begin
          r.re = unit_part(ar, r.mag);
          r.im = unit_part(ai, r.mag);
          r.mag = isqrt(r.re, r.im);
        end
      end
      capt_pkg::OpPeak: begin
        r.re = pk_re; r.im = pk_im; r.mag = pk_mag;
      end
      default: ;
    endcase
    if (made) begin
      r.mag = isqrt(r.re, r.im);
      if (r.mag > pk_mag) begin
        pk_mag = r.mag; pk_re = r.re; pk_im = r.im;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return MaxPos;
      1: return MinNeg;
      2: return $urandom_range(0, 4) << 16;
      3: return 32'($signed($urandom_range(0, 2000)) - 1000) << 12;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(capt_pkg::opcode_t op, logic [31:0] ar, ai, br, bi, logic known,
                      res_s want);
    res_s p;
    int   w;
    w = $urandom_range(0, 18);
    if (w > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {bi, br, ai, ar};
    do @(posedge clk_i); while (!s_axis_tready_o);
    p = predict(op, ar, ai, br, bi);
    if (known && p != want)
      $display("%0t table row disagrees with predictor: %p vs %p", $time, want, p);
    want_q.push_back(known ? want : p);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("complex_alu_with_peak_tracker_top: mismatch");
      $finish;
    end
  end

  // receiver with random stalls; one long hold-off while the sender keeps offering
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      w = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 18);
      if (hold_long) begin
        w = 600;
        hold_long = 0;
      end
      if (w > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    res_s got, exp_r;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.re  = m_axis_tdata_o[31:0];
      got.im  = m_axis_tdata_o[63:32];
      got.mag = m_axis_tdata_o[95:64];
      got.cmp = m_axis_tdata_o[96];
      got.sat = m_axis_tdata_o[97];
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: %p", $time, got);
      end else begin
        exp_r = want_q.pop_front();
        if (got != exp_r) begin
          errors++;
          $display("%0t expected %p actual %p", $time, exp_r, got);
        end
      end
    end
  end

  row_s rows[$];
  res_s z;

  initial begin
    capt_pkg::opcode_t op;
    z = '{default: '0};
    pk_re = 0; pk_im = 0; pk_mag = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows = '{
      '{capt_pkg::OpPeak, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0}},
      '{capt_pkg::OpLoad, 32'h0003_0000, 32'h0004_0000, 0, 0, 1,
        '{32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 0, 0}},
      '{capt_pkg::OpPeak, 0, 0, 0, 0, 1,
        '{32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 0, 0}},
      '{capt_pkg::OpLoad, 32'h0004_0000, 32'h0003_0000, 0, 0, 0, z},
      '{capt_pkg::OpPeak, 0, 0, 0, 0, 1,
        '{32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 0, 0}},
      '{capt_pkg::OpNeg, MinNeg, MaxPos, 0, 0, 1,
        '{MaxPos, 32'h8000_0001, 32'hb504_f332, 0, 0}},
      '{capt_pkg::OpAdd, MaxPos, MinNeg, 1, MinNeg, 1,
        '{MaxPos, MinNeg, 32'hb504_f333, 0, 1}},
      '{capt_pkg::OpSub, MinNeg, MaxPos, 1, 32'hffff_ffff, 0, z},
      '{capt_pkg::OpMul, MaxPos, MaxPos, MaxPos, MinNeg, 0, z},
      '{capt_pkg::OpMul, MinNeg, MinNeg, MinNeg, MinNeg, 0, z},
      '{capt_pkg::OpMul, 32'h0001_0000, 0, 32'h1234_5678, 32'hfedc_ba98, 0, z},
      '{capt_pkg::OpEq, 5, 6, 5, 6, 1, '{0, 0, 0, 1, 0}},
      '{capt_pkg::OpEq, 5, 6, 5, 7, 1, '{0, 0, 0, 0, 0}},
      '{capt_pkg::OpNe, 5, 6, 5, 6, 1, '{0, 0, 0, 0, 0}},
      '{capt_pkg::OpNe, MaxPos, 0, MinNeg, 0, 1, '{0, 0, 0, 1, 0}},
      '{capt_pkg::OpMag, MinNeg, MinNeg, 0, 0, 0, z},
      '{capt_pkg::OpNorm, 0, 0, 3, 3, 1, '{0, 0, 0, 0, 0}},
      '{capt_pkg::OpNorm, 32'h0003_0000, 32'hfffc_0000, 0, 0, 0, z},
      '{capt_pkg::OpNorm, 1, 0, 0, 0, 0, z},
      '{capt_pkg::OpNorm, MinNeg, 1, 0, 0, 0, z},
      '{capt_pkg::OpPeak, 0, 0, 0, 0, 0, z},
      '{capt_pkg::opcode_t'(10), 1, 2, 3, 4, 1, '{0, 0, 0, 0, 0}},
      '{capt_pkg::opcode_t'(15), MaxPos, MaxPos, MaxPos, MaxPos, 1, '{0, 0, 0, 0, 0}}
    };
    foreach (rows[i])
      send(rows[i].op, rows[i].ar, rows[i].ai, rows[i].br, rows[i].bi,
           rows[i].known, rows[i].want);

    for (int n = 0; n < 850; n++) begin
      logic [31:0] ar, ai, br, bi;
      if (n == 300) hold_long = 1;
      op = ($urandom_range(0, 30) == 0) ? capt_pkg::opcode_t'($urandom_range(10, 15))
                                        : capt_pkg::opcode_t'($urandom_range(0, 9));
      ar = rnd_word(); ai = rnd_word(); br = rnd_word(); bi = rnd_word();
      if ((op == capt_pkg::OpEq || op == capt_pkg::OpNe) && $urandom_range(0, 1)) begin
        br = ar; bi = ai;
        if ($urandom_range(0, 1)) bi[$urandom_range(0, 31)] ^= 1'b1;
      end
      send(op, ar, ai, br, bi, 1'b0, z);
    end
    s_axis_tvalid_i <= 1'b0;

    wait (want_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("complex_alu_with_peak_tracker_top: match");
    end else begin
      $display("complex_alu_with_peak_tracker_top: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/capt_pkg.sv
sv/capt_front.sv
sv/capt_back.sv
sv/complex_alu_with_peak_tracker_top.sv
dv/testbench.sv
